/* rtl/rct_pkg.sv */
// Shared types and codes for the residency count table.
// Used by rct_cell, residency_count_table, rct_checker and the testbench; depends on nothing else.
package rct_pkg;

    typedef enum logic {
        OP_OBSERVE = 1'b0,
        OP_READ    = 1'b1
    } op_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef struct packed {
        op_t         operation;
        logic [19:0] item_id;
        logic [5:0]  entry_index;
    } request_t;

    typedef struct packed {
        logic [5:0]  position;
        logic [19:0] entry_id;
        logic [23:0] residency;
        logic        is_tracked;
        logic [6:0]  entry_count;
        logic [1:0]  status;
    } result_t;

    // Control part of the token that walks down the cell row.
    typedef struct packed {
        logic active;
        logic done;
        logic inserted;
    } token_t;

endpackage

/* rtl/rct_cell.sv */
// One table entry of the residency count table: id, counter and one token stage.
// Depends on rct_pkg.
module rct_cell
    import rct_pkg::*;
#(
    parameter int ID_BITS    = 20,
    parameter int COUNT_BITS = 24,
    parameter int POS_BITS   = 6,
    parameter int FILL_BITS  = 7,
    parameter int CELL_INDEX = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  op_t                   op,
    input  logic [ID_BITS-1:0]    key_id,
    input  logic [5:0]            read_index,
    input  logic [FILL_BITS-1:0]  fill_level,
    input  token_t                tok_in,
    input  logic [POS_BITS-1:0]   pos_in,
    input  logic [ID_BITS-1:0]    id_in,
    input  logic [COUNT_BITS-1:0] cnt_in,
    output token_t                tok_out,
    output logic [POS_BITS-1:0]   pos_out,
    output logic [ID_BITS-1:0]    id_out,
    output logic [COUNT_BITS-1:0] cnt_out
);

    logic [ID_BITS-1:0]    id_reg,  id_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    token_t                tok_reg, tok_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [ID_BITS-1:0]    rid_reg, rid_next;
    logic [COUNT_BITS-1:0] rcnt_reg, rcnt_next;

    logic                  occupied;
    logic                  at_fill;
    logic                  live;
    logic                  hit;
    logic                  ins;
    logic                  rd;
    logic [COUNT_BITS-1:0] cnt_inc;

    assign occupied = FILL_BITS'(CELL_INDEX) < fill_level;
    assign at_fill  = FILL_BITS'(CELL_INDEX) == fill_level;
    assign live     = tok_in.active && !tok_in.done;
    assign hit      = live && (op == OP_OBSERVE) && occupied && (id_reg == key_id);
    assign ins      = live && (op == OP_OBSERVE) && at_fill;
    assign rd       = live && (op == OP_READ) && occupied
                      && (32'(read_index) == 32'(CELL_INDEX));
    // The counter holds at its maximum instead of wrapping.
    assign cnt_inc  = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;

    always_comb
    begin
        id_next  = id_reg;
        cnt_next = cnt_reg;
        if (hit)
        begin
            cnt_next = cnt_inc;
        end
        if (ins)
        begin
            id_next  = key_id;
            cnt_next = COUNT_BITS'(1);
        end
    end

    always_comb
    begin
        tok_next.active   = tok_in.active;
        tok_next.done     = tok_in.done || hit || ins || rd;
        tok_next.inserted = tok_in.inserted || ins;
        pos_next          = pos_in;
        rid_next          = id_in;
        rcnt_next         = cnt_in;
        if (hit || ins || rd)
        begin
            pos_next = POS_BITS'(CELL_INDEX);
        end
        if (hit)
        begin
            rid_next  = id_reg;
            rcnt_next = cnt_inc;
        end
        if (ins)
        begin
            rid_next  = key_id;
            rcnt_next = COUNT_BITS'(1);
        end
        if (rd)
        begin
            rid_next  = id_reg;
            rcnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        cnt_reg  <= cnt_next;
        pos_reg  <= pos_next;
        rid_reg  <= rid_next;
        rcnt_reg <= rcnt_next;
    end

    assign tok_out = tok_reg;
    assign pos_out = pos_reg;
    assign id_out  = rid_reg;
    assign cnt_out = rcnt_reg;

endmodule

/* rtl/residency_count_table.sv */
// Top level of the residency count table: item capture, cell row and result stage.
// Depends on rct_pkg and rct_cell.
//
//   channel   | ports                       | handshake
//   ----------+-----------------------------+------------------------------------
//   request   | start, busy, request        | taken when start=1 and busy=0
//   result    | result_valid, result        | one-cycle strobe, cannot be held off
//   config    | cfg_valid, cfg_ready, cfg_data | written when valid and ready
//
// An item walks the row of TABLE_DEPTH cells one cell per cycle. The result strobe
// rises once the token has left the last cell and its result is registered; the
// block takes no new item until the token of the last one has left the row.
// The next item may be taken in the cycle its predecessor's result is shown.
// Reset empties the table and sets the threshold to 10; cfg_ready is always high.
module residency_count_table
    import rct_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int ID_BITS     = 20,
    parameter int COUNT_BITS  = 24
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     result_valid,
    output result_t  result,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [23:0] cfg_data
);

    localparam int POS_BITS  = $clog2(TABLE_DEPTH);
    localparam int FILL_BITS = $clog2(TABLE_DEPTH + 1);

    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic [ID_BITS-1:0]   key_reg;
    logic [5:0]           index_reg;
    token_t               launch_reg, launch_next;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    logic [23:0]          thr_reg;
    logic                 result_valid_reg;
    result_t              result_reg, result_next;
    logic                 accept;
    logic                 finish;

    token_t                tok_chain [0:TABLE_DEPTH];
    logic [POS_BITS-1:0]   pos_chain [0:TABLE_DEPTH];
    logic [ID_BITS-1:0]    id_chain  [0:TABLE_DEPTH];
    logic [COUNT_BITS-1:0] cnt_chain [0:TABLE_DEPTH];

    logic [31:0] pos_wide;
    logic [31:0] id_wide;
    logic [31:0] cnt_wide;
    logic [31:0] fill_wide;
    logic [31:0] key_wide;

    assign finish = tok_chain[TABLE_DEPTH].active;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE: busy = 1'b0;
            ST_WALK: busy = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign key_wide  = 32'(request.item_id);

    always_comb
    begin
        launch_next.active   = accept;
        launch_next.done     = 1'b0;
        launch_next.inserted = 1'b0;
    end

    assign tok_chain[0] = launch_reg;
    assign pos_chain[0] = '0;
    assign id_chain[0]  = '0;
    assign cnt_chain[0] = '0;

    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        rct_cell #(
            .ID_BITS    (ID_BITS),
            .COUNT_BITS (COUNT_BITS),
            .POS_BITS   (POS_BITS),
            .FILL_BITS  (FILL_BITS),
            .CELL_INDEX (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op_reg),
            .key_id     (key_reg),
            .read_index (index_reg),
            .fill_level (fill_reg),
            .tok_in     (tok_chain[k]),
            .pos_in     (pos_chain[k]),
            .id_in      (id_chain[k]),
            .cnt_in     (cnt_chain[k]),
            .tok_out    (tok_chain[k+1]),
            .pos_out    (pos_chain[k+1]),
            .id_out     (id_chain[k+1]),
            .cnt_out    (cnt_chain[k+1])
        );
    end

    assign pos_wide  = 32'(pos_chain[TABLE_DEPTH]);
    assign id_wide   = 32'(id_chain[TABLE_DEPTH]);
    assign cnt_wide  = 32'(cnt_chain[TABLE_DEPTH]);

    always_comb
    begin
        fill_next = fill_reg;
        if (finish && tok_chain[TABLE_DEPTH].inserted)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    assign fill_wide = 32'(fill_next);

    // A token that leaves the row without a match either found the table full
    // or asked for a position that holds no entry.
    always_comb
    begin
        result_next             = '0;
        result_next.entry_count = fill_wide[6:0];
        if (tok_chain[TABLE_DEPTH].done)
        begin
            result_next.position   = pos_wide[5:0];
            result_next.entry_id   = id_wide[19:0];
            result_next.residency  = cnt_wide[23:0];
            result_next.is_tracked = cnt_wide > 32'(thr_reg);
            result_next.status     = STATUS_OK;
        end
        else if (op_reg == OP_READ)
        begin
            result_next.position = index_reg;
            result_next.status   = STATUS_RANGE;
        end
        else
        begin
            result_next.status = STATUS_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            launch_reg       <= '0;
            fill_reg         <= '0;
            thr_reg          <= 24'd10;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            launch_reg       <= launch_next;
            fill_reg         <= fill_next;
            result_valid_reg <= finish;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= request.operation;
            key_reg   <= key_wide[ID_BITS-1:0];
            index_reg <= request.entry_index;
        end
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* tb/sv/rct_checker.sv */
// Scoreboard for the residency count table: predicts every result and compares it.
// Depends on rct_pkg; instantiated beside the block by tb_residency_count_table.
module rct_checker
    import rct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  request_t    request,
    input  logic        result_valid,
    input  result_t     result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [23:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          results_checked,
    output int          full_seen,
    output int          range_seen,
    output int          tracked_seen
);

    localparam int DEPTH = 64;

    // Shadow copy of the table; entries at or above shadow_fill are never read.
    logic [19:0] shadow_ids [DEPTH];
    logic [23:0] shadow_counts [DEPTH];
    logic [6:0]  shadow_fill;
    logic [23:0] threshold;

    result_t entry_reports_due [$];
    result_t want;

    // Applies one item to the shadow table and returns the report it should produce.
    function automatic result_t lookup_entry(input request_t req);
        result_t r;
        int      hit;
        r   = '0;
        hit = -1;
        if (req.operation == OP_OBSERVE)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (hit < 0 && i < shadow_fill && shadow_ids[i] == req.item_id)
                    hit = i;
            end
            if (hit >= 0)
            begin
                if (shadow_counts[hit] != 24'hFFFFFF)
                    shadow_counts[hit] = shadow_counts[hit] + 24'd1;
                r.position  = hit[5:0];
                r.entry_id  = shadow_ids[hit];
                r.residency = shadow_counts[hit];
                r.status    = STATUS_OK;
            end
            else if (shadow_fill < DEPTH)
            begin
                shadow_ids[shadow_fill[5:0]]    = req.item_id;
                shadow_counts[shadow_fill[5:0]] = 24'd1;
                r.position  = shadow_fill[5:0];
                r.entry_id  = req.item_id;
                r.residency = 24'd1;
                r.status    = STATUS_OK;
                shadow_fill = shadow_fill + 7'd1;
            end
            else
            begin
                r.status = STATUS_FULL;
            end
        end
        else
        begin
            r.position = req.entry_index;
            if ({1'b0, req.entry_index} < shadow_fill)
            begin
                r.entry_id  = shadow_ids[req.entry_index];
                r.residency = shadow_counts[req.entry_index];
                r.status    = STATUS_OK;
            end
            else
            begin
                r.status = STATUS_RANGE;
            end
        end
        r.is_tracked  = (r.status == STATUS_OK) && (r.residency > threshold);
        r.entry_count = shadow_fill;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_fill = '0;
            threshold   = 24'd10;
            entry_reports_due.delete();
            fail_count      = 0;
            pending         = 0;
            results_checked = 0;
            full_seen       = 0;
            range_seen      = 0;
            tracked_seen    = 0;
        end
        else
        begin
            // The result shown in this cycle always belongs to an item taken earlier.
            if (result_valid)
            begin
                results_checked++;
                if (result.status == STATUS_FULL)
                    full_seen++;
                if (result.status == STATUS_RANGE)
                    range_seen++;
                if (result.is_tracked)
                    tracked_seen++;
                if (entry_reports_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"[%0t] unexpected result: ",
                                  "pos=%0d id=%h res=%0d trk=%0b cnt=%0d st=%0d"},
                                 $realtime, result.position, result.entry_id,
                                 result.residency, result.is_tracked,
                                 result.entry_count, result.status);
                end
                else
                begin
                    want = entry_reports_due.pop_front();
                    if (result.position !== want.position || result.entry_id !== want.entry_id
                        || result.residency !== want.residency
                        || result.is_tracked !== want.is_tracked
                        || result.entry_count !== want.entry_count
                        || result.status !== want.status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"[%0t] mismatch: expected ",
                                      "pos=%0d id=%h res=%0d trk=%0b cnt=%0d st=%0d, ",
                                      "got pos=%0d id=%h res=%0d trk=%0b cnt=%0d st=%0d"},
                                     $realtime, want.position, want.entry_id,
                                     want.residency, want.is_tracked,
                                     want.entry_count, want.status,
                                     result.position, result.entry_id,
                                     result.residency, result.is_tracked,
                                     result.entry_count, result.status);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                threshold = cfg_data;
            if (start && !busy)
                entry_reports_due.push_back(lookup_entry(request));
            pending = entry_reports_due.size();
        end
    end

endmodule

/* tb/sv/tb_residency_count_table.sv */
// Stimulus and verdict for residency_count_table: directed items, then random phases.
// Depends on rct_pkg, residency_count_table and rct_checker.
module tb_residency_count_table;
    import rct_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start;
    logic        busy;
    request_t    request;
    logic        result_valid;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [23:0] cfg_data;

    int fail_count;
    int pending;
    int results_checked;
    int full_seen;
    int range_seen;
    int tracked_seen;

    int observes_sent = 0;
    int reads_sent = 0;
    int settings_used = 1;
    int quiet_cycles = 0;

    // Every id offered so far; after the table fills, some of these were never stored.
    logic [19:0] id_pool [$];

    residency_count_table dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    rct_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .request         (request),
        .result_valid    (result_valid),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .full_seen       (full_seen),
        .range_seen      (range_seen),
        .tracked_seen    (tracked_seen)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_residency_count_table failed");
        $finish;
    end

    function automatic request_t make_item(input op_t op, input logic [19:0] id,
                                           input logic [5:0] idx);
        request_t r;
        r.operation   = op;
        r.item_id     = id;
        r.entry_index = idx;
        return r;
    endfunction

    // Mostly repeat observations of known ids, some new ids and plenty of reads.
    function automatic request_t random_item();
        request_t r;
        int       pick;
        pick          = $urandom_range(0, 99);
        r.item_id     = 20'($urandom);
        r.entry_index = 6'($urandom);
        if (pick < 37)
        begin
            r.operation = OP_READ;
        end
        else if (pick < 45 || id_pool.size() == 0)
        begin
            r.operation = OP_OBSERVE;
            id_pool.push_back(r.item_id);
        end
        else
        begin
            r.operation = OP_OBSERVE;
            r.item_id   = id_pool[$urandom_range(0, id_pool.size() - 1)];
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input request_t req);
        start   <= 1'b1;
        request <= req;
        if (req.operation == OP_OBSERVE)
            observes_sent++;
        else
            reads_sent++;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_threshold(input logic [23:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input logic [23:0] value, input int idle_pct, input int items);
        write_threshold(value);
        for (int k = 0; k < items; k++)
        begin
            send_item(random_item());
            if ($urandom_range(0, 199) == 0)
            begin
                drain();
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 80)) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table, reset threshold: reads out of range, first inserts and hits.
        send_item(make_item(OP_READ, 20'h00000, 6'd0));
        send_item(make_item(OP_READ, 20'hFFFFF, 6'd63));
        send_item(make_item(OP_OBSERVE, 20'h00000, 6'd0));
        send_item(make_item(OP_OBSERVE, 20'hFFFFF, 6'd0));
        send_item(make_item(OP_OBSERVE, 20'h00000, 6'd63));
        send_item(make_item(OP_READ, 20'h00000, 6'd0));
        send_item(make_item(OP_READ, 20'h00000, 6'd1));
        send_item(make_item(OP_READ, 20'h00000, 6'd2));
        send_item(make_item(OP_READ, 20'hFFFFF, 6'd1));
        send_item(make_item(OP_OBSERVE, 20'h00000, 6'd0));
        id_pool.push_back(20'h00000);
        id_pool.push_back(20'hFFFFF);

        write_threshold(24'd1);
        send_item(make_item(OP_READ, 20'h00000, 6'd0));
        send_item(make_item(OP_READ, 20'h00000, 6'd1));
        send_item(make_item(OP_OBSERVE, 20'hFFFFF, 6'd0));

        // With a zero threshold a fresh entry is tracked at once.
        write_threshold(24'd0);
        send_item(make_item(OP_OBSERVE, 20'h55555, 6'd21));
        send_item(make_item(OP_OBSERVE, 20'hAAAAA, 6'd42));
        send_item(make_item(OP_READ, 20'h55555, 6'd3));
        id_pool.push_back(20'h55555);
        id_pool.push_back(20'hAAAAA);

        run_phase(24'hFFFFFF, 0, 490);
        run_phase(24'd10, 74, 490);
        run_phase(24'($urandom_range(0, 40)), 0, 490);
        run_phase(24'd0, 7, 490);

        drain();
        repeat (70) @(negedge clk);
        $display("Summary: %0d observe and %0d read items over %0d threshold settings,",
                 observes_sent, reads_sent, settings_used);
        $display("Summary: %0d results compared, %0d table-full reports,", results_checked,
                 full_seen);
        $display("Summary: %0d out-of-range reads, %0d tracked entries reported.",
                 range_seen, tracked_seen);
        if (fail_count == 0 && pending == 0)
            $display("tb_residency_count_table passed");
        else
            $display("tb_residency_count_table failed");
        $finish;
    end

endmodule
